### design/asfe_pkg.sv
// ----------------------------------------------------------------------------
// asfe_pkg
// Shared types and constants of the audio sample engine.
// ----------------------------------------------------------------------------
package asfe_pkg;

  localparam int DEF_FIFO_DEPTH   = 2048;
  localparam int DEF_TICK_RATE_HZ = 8000;

  localparam int OP_W    = 3;
  localparam int BYTE_W  = 8;
  localparam int ADC_W   = 10;
  localparam int BLEN_W  = 16;
  localparam int FREQ_W  = 12;
  localparam int MODE_W  = 2;
  localparam int FMT_W   = 2;
  localparam int TRIM_W  = 10;
  localparam int FILL_W  = 12;
  localparam int TICKS_W = 20;
  localparam int CIDX_W  = 2;

  localparam logic [MODE_W-1:0] MODE_PLAY   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RECORD = 2'd2;

  localparam logic [FMT_W-1:0] FMT_MONO8    = 2'd0;
  localparam logic [FMT_W-1:0] FMT_STEREO8  = 2'd1;
  localparam logic [FMT_W-1:0] FMT_MONO16   = 2'd2;
  localparam logic [FMT_W-1:0] FMT_STEREO16 = 2'd3;

  localparam logic [CIDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_FORMAT = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_TRIM   = 2'd2;

  localparam logic signed [11:0] REC_OFFSET = -12'sd384;
  localparam logic [BYTE_W-1:0]  LEVEL_MID  = 8'h80;
  localparam logic [BYTE_W-1:0]  LEVEL_MAX  = 8'hFF;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_TICK  = 3'd2,
    OP_BEEP  = 3'd3,
    OP_FLUSH = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    KIND_PUSH       = 3'd0,
    KIND_POP        = 3'd1,
    KIND_PLAY       = 3'd2,
    KIND_RECORD     = 3'd3,
    KIND_BEEP_TICK  = 3'd4,
    KIND_BEEP_START = 3'd5,
    KIND_FLUSH      = 3'd6,
    KIND_NOP        = 3'd7
  } kind_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [FMT_W-1:0]  format;
    logic [TRIM_W-1:0] trim;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] data;
    logic [ADC_W-1:0]  adc;
    logic [BLEN_W-1:0] blen;
    logic [FREQ_W-1:0] bfreq;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] left;
    logic [BYTE_W-1:0] right;
    logic [BYTE_W-1:0] rbyte;
    logic              rvalid;
    logic [FILL_W-1:0] fill;
    logic              drop;
  } res_t;

endpackage

### design/audio_sample_fifo_engine_unit.sv
// ----------------------------------------------------------------------------
// audio_sample_fifo_engine_unit
// Each input word passes through the front queue, the back's execute and
// finish steps around the sample ring's registered read, and the result queue.
// The back takes no new word until its finish step pushes the last result; a
// running beep's tick also runs the two-step reciprocal multiply for the phase.
// Reset: queues empty, ring empty, levels at center, beep off, registers zero.
// ----------------------------------------------------------------------------
module audio_sample_fifo_engine_unit import asfe_pkg::*; #(
  parameter int FIFO_DEPTH   = DEF_FIFO_DEPTH,
  parameter int TICK_RATE_HZ = DEF_TICK_RATE_HZ
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [TRIM_W-1:0] cfg_data_i,
  input  logic              push,
  output logic              full,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic [ADC_W-1:0]  adc_sample_i,
  input  logic [BLEN_W-1:0] beep_length_ms_i,
  input  logic [FREQ_W-1:0] beep_freq_hz_i,
  output logic              empty,
  input  logic              pop,
  output logic [BYTE_W-1:0] left_level_o,
  output logic [BYTE_W-1:0] right_level_o,
  output logic [BYTE_W-1:0] read_byte_o,
  output logic              read_valid_o,
  output logic [FILL_W-1:0] fill_level_o,
  output logic              dropped_o
);

  cfg_t cfg_q;
  logic cmd_valid, cmd_pop, res_full, res_push;
  cmd_t cmd;
  res_t res_in, res_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MODE:   cfg_q.mode   <= cfg_data_i[MODE_W-1:0];
        CFG_FORMAT: cfg_q.format <= cfg_data_i[FMT_W-1:0];
        CFG_TRIM:   cfg_q.trim   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  asfe_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .push             (push),
    .full             (full),
    .operation_i      (operation_i),
    .data_byte_i      (data_byte_i),
    .adc_sample_i     (adc_sample_i),
    .beep_length_ms_i (beep_length_ms_i),
    .beep_freq_hz_i   (beep_freq_hz_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd),
    .cmd_pop_i        (cmd_pop)
  );

  asfe_back #(
    .FIFO_DEPTH   (FIFO_DEPTH),
    .TICK_RATE_HZ (TICK_RATE_HZ)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  asfe_res_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (res_out)
  );

  assign left_level_o  = res_out.left;
  assign right_level_o = res_out.right;
  assign read_byte_o   = res_out.rbyte;
  assign read_valid_o  = res_out.rvalid;
  assign fill_level_o  = res_out.fill;
  assign dropped_o     = res_out.drop;

endmodule

### design/asfe_front.sv
// ----------------------------------------------------------------------------
// asfe_front
// Accepts input words, classifies them into commands and queues them.
// ----------------------------------------------------------------------------
module asfe_front import asfe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              push,
  output logic              full,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic [ADC_W-1:0]  adc_sample_i,
  input  logic [BLEN_W-1:0] beep_length_ms_i,
  input  logic [FREQ_W-1:0] beep_freq_hz_i,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              cmd_pop_i
);

  cmd_t       ent_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_new;
  logic       do_push, do_pop;

  always_comb begin
    cmd_new.data  = data_byte_i;
    cmd_new.adc   = adc_sample_i;
    cmd_new.blen  = beep_length_ms_i;
    cmd_new.bfreq = beep_freq_hz_i;
    case (op_e'(operation_i))
      OP_PUSH:  cmd_new.kind = KIND_PUSH;
      OP_POP:   cmd_new.kind = KIND_POP;
      OP_TICK: begin
        if (cfg_i.mode == MODE_PLAY) begin
          cmd_new.kind = KIND_PLAY;
        end else if (cfg_i.mode == MODE_RECORD) begin
          cmd_new.kind = KIND_RECORD;
        end else begin
          cmd_new.kind = KIND_BEEP_TICK;
        end
      end
      OP_BEEP:  cmd_new.kind = KIND_BEEP_START;
      OP_FLUSH: cmd_new.kind = KIND_FLUSH;
      default:  cmd_new.kind = KIND_NOP;
    endcase
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = ent_q[rd_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

### design/asfe_back.sv
// ----------------------------------------------------------------------------
// asfe_back
// Executes queued commands against the sample ring, levels and beep timer.
// ----------------------------------------------------------------------------
module asfe_back import asfe_pkg::*; #(
  parameter int FIFO_DEPTH   = DEF_FIFO_DEPTH,
  parameter int TICK_RATE_HZ = DEF_TICK_RATE_HZ
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o
);

  localparam int PTR_W   = $clog2(FIFO_DEPTH);
  localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
  localparam int RCP_SH  = $clog2(TICK_RATE_HZ);
  localparam int RCP_W   = 34;
  localparam int PROD_W  = 32;
  localparam int HALF_W  = 16;
  localparam int PART_W  = HALF_W + RCP_W;
  localparam int ACC_W   = PROD_W + RCP_W;
  localparam int PAR_BIT = PROD_W + RCP_SH;

  // The tone phase is floor(2 * ticks * pitch / rate); its low bit is bit
  // PAR_BIT of ticks * pitch * RECIP, exact for every 32-bit product.
  localparam logic [63:0] RCP_FULL =
    ((64'd1 << (33 + RCP_SH)) + 64'(TICK_RATE_HZ) - 64'd1) / 64'(TICK_RATE_HZ);
  localparam logic [RCP_W-1:0] RECIP = RCP_FULL[RCP_W-1:0];

  typedef enum logic [2:0] {
    ST_EXEC = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIN  = 3'b100
  } back_state_e;

  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
                                                 input logic [2:0] k);
    logic [PTR_W:0] s;
    s = {1'b0, p} + (PTR_W+1)'(k);
    if (s >= (PTR_W+1)'(FIFO_DEPTH)) begin
      s = s - (PTR_W+1)'(FIFO_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  logic [BYTE_W-1:0] mem_q [FIFO_DEPTH];
  logic [BYTE_W-1:0] rdata_a_q, rdata_b_q;

  back_state_e         state_q, state_d;
  logic [PTR_W-1:0]    rp_q, rp_d, wp_q, wp_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [BYTE_W-1:0]   left_q, left_d, right_q, right_d;
  logic [TICKS_W-1:0]  ticks_q, ticks_d;
  logic [FREQ_W-1:0]   pitch_q, pitch_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic                step_q, step_d;
  logic                drop_q, drop_d, pop_ok_q, pop_ok_d, play_ok_q, play_ok_d;

  logic                mem_we, mem_re;
  logic [PTR_W-1:0]    mem_wa, addr_a, addr_b;
  logic [BYTE_W-1:0]   mem_wd;
  logic [2:0]          need, off_a, off_b;
  logic                is16, not_full;
  logic [ADC_W-1:0]    adc_off;
  logic signed [11:0]  trim_ext, rec_sum;
  logic [BYTE_W-1:0]   rec_val;
  logic [PROD_W-1:0]   beep_prod;
  logic [HALF_W-1:0]   half;
  logic [PART_W-1:0]   part;
  logic [ACC_W-1:0]    acc_sum;
  logic                phase_odd;

  always_comb begin
    is16 = (cfg_i.format == FMT_MONO16) || (cfg_i.format == FMT_STEREO16);
    case (cfg_i.format)
      FMT_MONO8:    need = 3'd1;
      FMT_STEREO8:  need = 3'd2;
      FMT_MONO16:   need = 3'd2;
      default:      need = 3'd4;
    endcase
    off_a  = (cmd_i.kind == KIND_PLAY && is16) ? 3'd1 : 3'd0;
    off_b  = (cfg_i.format == FMT_STEREO16) ? 3'd3 : 3'd1;
    addr_a = ring_add(rp_q, off_a);
    addr_b = ring_add(rp_q, off_b);
    not_full = (cnt_q < CNT_W'(FIFO_DEPTH));

    adc_off  = {~cmd_i.adc[ADC_W-1], cmd_i.adc[ADC_W-2:0]};
    trim_ext = {{2{cfg_i.trim[TRIM_W-1]}}, cfg_i.trim};
    rec_sum  = $signed({2'b00, adc_off}) + REC_OFFSET + trim_ext;
    if (rec_sum < 0) begin
      rec_val = 8'h00;
    end else if (rec_sum > 12'sd255) begin
      rec_val = LEVEL_MAX;
    end else begin
      rec_val = rec_sum[BYTE_W-1:0];
    end

    beep_prod = PROD_W'(ticks_q) * PROD_W'(pitch_q);
    half      = step_q ? prod_q[PROD_W-1:HALF_W] : prod_q[HALF_W-1:0];
    part      = PART_W'(half) * PART_W'(RECIP);
    acc_sum   = acc_q + (ACC_W'(part) << HALF_W);
    phase_odd = acc_sum[PAR_BIT];
  end

  always_comb begin
    state_d   = state_q;
    rp_d      = rp_q;
    wp_d      = wp_q;
    cnt_d     = cnt_q;
    left_d    = left_q;
    right_d   = right_q;
    ticks_d   = ticks_q;
    pitch_d   = pitch_q;
    prod_d    = prod_q;
    acc_d     = acc_q;
    step_d    = step_q;
    drop_d    = drop_q;
    pop_ok_d  = pop_ok_q;
    play_ok_d = play_ok_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wa    = wp_q;
    mem_wd    = cmd_i.data;
    cmd_pop_o = 1'b0;
    res_push_o = 1'b0;

    case (state_q)
      ST_EXEC: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          drop_d    = 1'b0;
          pop_ok_d  = 1'b0;
          play_ok_d = 1'b0;
          state_d   = ST_FIN;
          case (cmd_i.kind)
            KIND_PUSH, KIND_RECORD: begin
              if (cmd_i.kind == KIND_RECORD) begin
                right_d = rec_val;
                mem_wd  = rec_val;
              end
              if (not_full) begin
                mem_we = 1'b1;
                wp_d   = ring_add(wp_q, 3'd1);
                cnt_d  = cnt_q + CNT_W'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
            KIND_POP: begin
              if (cnt_q != '0) begin
                mem_re   = 1'b1;
                pop_ok_d = 1'b1;
                rp_d     = ring_add(rp_q, 3'd1);
                cnt_d    = cnt_q - CNT_W'(1);
              end
            end
            KIND_PLAY: begin
              if (cnt_q >= CNT_W'(need)) begin
                mem_re    = 1'b1;
                play_ok_d = 1'b1;
                rp_d      = ring_add(rp_q, need);
                cnt_d     = cnt_q - CNT_W'(need);
              end
            end
            KIND_BEEP_TICK: begin
              if (ticks_q != '0) begin
                prod_d  = beep_prod;
                step_d  = 1'b0;
                ticks_d = ticks_q - TICKS_W'(1);
                state_d = ST_DIV;
              end
            end
            KIND_BEEP_START: begin
              ticks_d = TICKS_W'({cmd_i.blen, 3'b000});
              pitch_d = cmd_i.bfreq;
            end
            KIND_FLUSH: begin
              rp_d  = '0;
              wp_d  = '0;
              cnt_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        if (!step_q) begin
          acc_d  = ACC_W'(part);
          step_d = 1'b1;
        end else begin
          left_d  = phase_odd ? 8'h00 : LEVEL_MAX;
          right_d = phase_odd ? 8'h00 : LEVEL_MAX;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (play_ok_q) begin
          case (cfg_i.format)
            FMT_MONO8: begin
              left_d  = rdata_a_q;
              right_d = rdata_a_q;
            end
            FMT_STEREO8: begin
              left_d  = rdata_a_q;
              right_d = rdata_b_q;
            end
            FMT_MONO16: begin
              left_d  = rdata_a_q + LEVEL_MID;
              right_d = rdata_a_q + LEVEL_MID;
            end
            default: begin
              left_d  = rdata_a_q + LEVEL_MID;
              right_d = rdata_b_q + LEVEL_MID;
            end
          endcase
        end
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      default: state_d = ST_EXEC;
    endcase
  end

  assign res_o.left   = left_d;
  assign res_o.right  = right_d;
  assign res_o.rbyte  = pop_ok_q ? rdata_a_q : 8'h00;
  assign res_o.rvalid = pop_ok_q;
  assign res_o.fill   = FILL_W'(cnt_q);
  assign res_o.drop   = drop_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_a_q <= mem_q[addr_a];
      rdata_b_q <= mem_q[addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_EXEC;
      rp_q      <= '0;
      wp_q      <= '0;
      cnt_q     <= '0;
      left_q    <= LEVEL_MID;
      right_q   <= LEVEL_MID;
      ticks_q   <= '0;
      pitch_q   <= '0;
      step_q    <= 1'b0;
      drop_q    <= 1'b0;
      pop_ok_q  <= 1'b0;
      play_ok_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rp_q      <= rp_d;
      wp_q      <= wp_d;
      cnt_q     <= cnt_d;
      left_q    <= left_d;
      right_q   <= right_d;
      ticks_q   <= ticks_d;
      pitch_q   <= pitch_d;
      step_q    <= step_d;
      drop_q    <= drop_d;
      pop_ok_q  <= pop_ok_d;
      play_ok_q <= play_ok_d;
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(FIFO_DEPTH))
    else $error("Fill count exceeds the ring depth.");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CNT_W'(FIFO_DEPTH)) |-> (wp_q == rp_q))
    else $error("Ring pointers disagree with the fill count.");

  a_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && cmd_valid_i && cmd_i.kind == KIND_FLUSH)
    |=> (cnt_q == '0 && rp_q == '0 && wp_q == '0))
    else $error("Flush did not empty the ring.");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !step_q) |-> ($past(state_q) == ST_EXEC))
    else $error("Beep phase step entered without a tick.");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({drop_q, pop_ok_q, play_ok_q}))
    else $error("Conflicting result flags.");
`endif

endmodule

### design/asfe_res_queue.sv
// ----------------------------------------------------------------------------
// asfe_res_queue
// Two-entry queue holding finished result words for the consumer.
// ----------------------------------------------------------------------------
module asfe_res_queue import asfe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t data_o
);

  res_t       ent_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = ent_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
